@@ hw/rtl/skts_pkg.sv @@
// Package for the sorted key table search unit.
// Holds the table sizing constants, the word layout widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package skts_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int AW          = $clog2(MAX_ENTRIES);
    localparam int CW          = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_HI_W    = 64;
    localparam int KEY_LO_W    = 16;
    localparam int KEY_W       = KEY_HI_W + KEY_LO_W;
    localparam int POS_W       = 6;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 8;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SEARCH = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CMP,
        ST_SR_RD,
        ST_SR_CMP,
        ST_OUT
    } t_state;

endpackage

@@ hw/rtl/sorted_key_table_search_unit.sv @@
// Top level of the sorted key table search unit: a key memory kept in ascending order,
// one shared key comparator and a small sequencer for sorted insert and binary search.
// Depends on skts_pkg.
//
//  Channel   Dir  tdata                        tuser
//  s_axis    in   [63:0] key_high,[79:64] key_low  [0] func
//  m_axis    out  [5:0] position, [7:6] zero      [0] found, [1] table_full
//
// A load walks the stored keys from the top down through ST_LD_RD and ST_LD_CMP, moving each
// key greater than the new key up one place and writing the new key above the first key that
// is not greater, or at place 0. A load into a full table goes straight to its result word.
// A search stops at a hit or after at most 7 probes. One memory read and one compare per step.
// Reset clears the entry count and the sequencer, not the key memory; the input is not ready
// while a word is in work or while a result waits on o_m_axis_tready.
`timescale 1ns / 1ps

module sorted_key_table_search_unit
    import skts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // key_high, key_low
    input  logic                i_s_axis_tuser,   // func
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // position, zero fill
    output logic [1:0]          o_m_axis_tuser    // found, table_full
);

    t_state            r_state, n_state;
    logic [KEY_W-1:0]  r_key;
    logic              r_func;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hx, n_hx;
    logic [CW-1:0]     r_mid, n_mid;
    logic              r_found, n_found;
    logic              r_full, n_full;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic [KEY_W-1:0]  mem [MAX_ENTRIES];
    logic [KEY_W-1:0]  r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [KEY_W-1:0]  wr_data;

    logic              s_acc;
    logic              m_acc;
    logic              cmp_gt;
    logic              cmp_eq;
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid_calc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;

    // The shared comparator: stored key against the key in work.
    assign cmp_gt = r_rd_data > r_key;
    assign cmp_eq = r_rd_data == r_key;

    assign mid_sum  = ({1'b0, r_lo} + {1'b0, r_hx} - (CW+1)'(1)) >> 1;
    assign mid_calc = mid_sum[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser == FUNC_SEARCH) begin
                        n_state = ST_SR_RD;
                    end else if (r_count == CW'(MAX_ENTRIES)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_LD_RD;
                    end
                end
            end
            ST_LD_RD: begin
                n_state = (r_idx == '0) ? ST_OUT : ST_LD_CMP;
            end
            ST_LD_CMP: begin
                n_state = cmp_gt ? ST_LD_RD : ST_OUT;
            end
            ST_SR_RD: begin
                n_state = (r_lo < r_hx) ? ST_SR_CMP : ST_OUT;
            end
            ST_SR_CMP: begin
                n_state = cmp_eq ? ST_OUT : ST_SR_RD;
            end
            ST_OUT: begin
                if (m_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_lo    = r_lo;
        n_hx    = r_hx;
        n_mid   = r_mid;
        n_found = r_found;
        n_full  = r_full;
        n_pos   = r_pos;
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_key;
        unique case (r_state)
            ST_IDLE: begin
                n_idx   = r_count;
                n_lo    = '0;
                n_hx    = r_count;
                n_found = 1'b0;
                n_full  = (i_s_axis_tuser == FUNC_LOAD) && (r_count == CW'(MAX_ENTRIES));
                n_pos   = '0;
            end
            ST_LD_RD: begin
                rd_addr = AW'(r_idx - CW'(1));
                if (r_idx == '0) begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    n_found = 1'b1;
                    n_pos   = '0;
                end
            end
            ST_LD_CMP: begin
                we = 1'b1;
                if (cmp_gt) begin
                    wr_data = r_rd_data;
                    n_idx   = r_idx - CW'(1);
                end else begin
                    n_count = r_count + CW'(1);
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_idx);
                end
            end
            ST_SR_RD: begin
                rd_addr = mid_calc[AW-1:0];
                n_mid   = mid_calc;
            end
            ST_SR_CMP: begin
                if (cmp_eq) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_mid);
                end else if (cmp_gt) begin
                    n_hx = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_key  <= {i_s_axis_tdata[KEY_HI_W-1:0], i_s_axis_tdata[KEY_W-1:KEY_HI_W]};
            r_func <= i_s_axis_tuser;
        end
        r_idx   <= n_idx;
        r_lo    <= n_lo;
        r_hx    <= n_hx;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_full  <= n_full;
        r_pos   <= n_pos;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    // The position of a rejected load stays zero; r_func only qualifies that case.
    assign o_m_axis_tdata  = M_DATA_W'((r_func == FUNC_LOAD && r_full) ? '0 : r_pos);
    assign o_m_axis_tuser  = {r_full, r_found};

endmodule

@@ hw/rtl/skts_checker.sv @@
// Port checker for the sorted key table search unit, with its bind to the top level.
// Depends on skts_pkg.
`timescale 1ns / 1ps

module skts_checker
    import skts_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]          o_m_axis_tuser
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result word shown right after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("Input ready while a result word is pending.");

    a_found_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("Found and table full flagged together.");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("Nonzero position without a match.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("Stalled result word changed.");

endmodule

bind sorted_key_table_search_unit skts_checker u_skts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ sim/sorted_key_table_search_unit_tb.sv @@
// Testbench for sorted_key_table_search_unit: directed table of loads and searches, then
// random traffic checked against an in-bench sorted table with binary search.
// Depends on skts_pkg and the sorted_key_table_search_unit RTL.
`timescale 1ns / 1ps

module sorted_key_table_search_unit_tb;
    import skts_pkg::*;

    localparam int  RANDOM_ITEMS = 1375;
    localparam int  DRAIN_CYCLES = 140;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  HOLD_CYCLES  = 500;
    localparam logic [63:0] ONES_HI = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] ONES_LO = 16'hFFFF;

    typedef struct packed {
        logic          found;
        logic [5:0]    position;
        logic          table_full;
    } t_result;

    typedef struct packed {
        t_func         func;
        logic [63:0]   key_hi;
        logic [15:0]   key_lo;
        logic          fixed_exp;
        t_result       exp;
    } t_vec;

    localparam int N_DIRECTED = 25;
    localparam t_vec DIRECTED [0:N_DIRECTED-1] = '{
        '{FUNC_SEARCH, 64'h0, 16'h0, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{FUNC_LOAD, ONES_HI, ONES_LO, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{FUNC_LOAD, 64'h0, 16'h0, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{FUNC_LOAD, ONES_HI, ONES_LO, 1'b1, '{1'b1, 6'd2, 1'b0}},
        '{FUNC_SEARCH, ONES_HI, ONES_LO, 1'b0, '0},
        '{FUNC_SEARCH, 64'h0, 16'h0, 1'b0, '0},
        '{FUNC_SEARCH, ONES_HI, 16'hFFFE, 1'b0, '0},
        '{FUNC_SEARCH, 64'h0, 16'h1, 1'b0, '0},
        '{FUNC_LOAD, 64'h0, 16'h1, 1'b0, '0},
        '{FUNC_LOAD, 64'h8000_0000_0000_0000, 16'h0, 1'b0, '0},
        '{FUNC_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, '0},
        '{FUNC_SEARCH, 64'h8000_0000_0000_0000, 16'h0, 1'b0, '0},
        '{FUNC_SEARCH, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0, '0},
        '{FUNC_LOAD, 64'h0123_4567_89AB_CDEF, 16'h8000, 1'b0, '0},
        '{FUNC_LOAD, 64'h0123_4567_89AB_CDEF, 16'h8000, 1'b0, '0},
        '{FUNC_LOAD, 64'h0123_4567_89AB_CDEF, 16'h8000, 1'b0, '0},
        '{FUNC_SEARCH, 64'h0123_4567_89AB_CDEF, 16'h8000, 1'b0, '0},
        '{FUNC_SEARCH, 64'h0123_4567_89AB_CDEF, 16'h7FFF, 1'b0, '0},
        '{FUNC_LOAD, ONES_HI, 16'h0, 1'b0, '0},
        '{FUNC_SEARCH, ONES_HI, 16'h0, 1'b0, '0},
        '{FUNC_SEARCH, 64'h1, 16'h0, 1'b0, '0},
        '{FUNC_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b0, '0},
        '{FUNC_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b0, '0},
        '{FUNC_SEARCH, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b0, '0},
        '{FUNC_SEARCH, ONES_HI, ONES_LO, 1'b0, '0}
    };

    localparam logic [63:0] HIGH_POOL [0:3] = '{
        64'h0, ONES_HI, 64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;   // key_high, key_low
    logic                i_s_axis_tuser = 1'b0; // func
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;        // position, zero fill
    logic [1:0]          o_m_axis_tuser;        // found, table_full

    logic [KEY_W-1:0] model_keys [MAX_ENTRIES];
    int               model_count = 0;
    t_result          pending_results [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               words_accepted = 0;
    int               burst_left = 0;

    sorted_key_table_search_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sorted insert after any equal keys, and binary search with the same probe order.
    function automatic t_result apply_key_op(t_func f, logic [KEY_W-1:0] key);
        t_result r;
        int      j;
        int      lo_i;
        int      hi_i;
        int      mid;
        r = '0;
        if (f == FUNC_LOAD) begin
            if (model_count >= MAX_ENTRIES) begin
                r.table_full = 1'b1;
                return r;
            end
            j = model_count;
            while (j > 0 && model_keys[j-1] > key) begin
                model_keys[j] = model_keys[j-1];
                j--;
            end
            model_keys[j] = key;
            model_count++;
            r.found    = 1'b1;
            r.position = j[5:0];
            return r;
        end
        lo_i = 0;
        hi_i = model_count - 1;
        while (lo_i <= hi_i) begin
            mid = (lo_i + hi_i) / 2;
            if (model_keys[mid] == key) begin
                r.found    = 1'b1;
                r.position = mid[5:0];
                return r;
            end
            if (model_keys[mid] > key) hi_i = mid - 1;
            else lo_i = mid + 1;
        end
        return r;
    endfunction

    task automatic offer_word(input t_func f, input logic [63:0] kh, input logic [15:0] kl,
                              output t_result predicted);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {kl, kh};
        i_s_axis_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        burst_left--;
        words_accepted++;
        predicted = apply_key_op(f, {kh, kl});
    endtask

    // Mostly keys already stored or next to one, so searches hit and loads make duplicates.
    task automatic pick_key(output logic [63:0] kh, output logic [15:0] kl);
        int sel;
        int idx;
        sel = $urandom_range(0, 9);
        kh  = {$urandom, $urandom};
        kl  = 16'($urandom_range(0, 65535));
        if (model_count > 0 && sel < 4) begin
            idx = $urandom_range(0, model_count - 1);
            {kh, kl} = model_keys[idx];
        end else if (model_count > 0 && sel < 6) begin
            idx = $urandom_range(0, model_count - 1);
            if ($urandom_range(0, 1) == 1) {kh, kl} = model_keys[idx] + 80'd1;
            else {kh, kl} = model_keys[idx] - 80'd1;
        end else if (sel < 8) begin
            kh = HIGH_POOL[$urandom_range(0, 3)];
        end
    endtask

    initial begin
        t_result     predicted;
        t_func       f;
        logic [63:0] kh;
        logic [15:0] kl;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < N_DIRECTED; n++) begin
            offer_word(DIRECTED[n].func, DIRECTED[n].key_hi, DIRECTED[n].key_lo, predicted);
            if (DIRECTED[n].fixed_exp) pending_results.push_back(DIRECTED[n].exp);
            else pending_results.push_back(predicted);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_key(kh, kl);
            if (model_count < MAX_ENTRIES) begin
                f = ($urandom_range(0, 99) < 30) ? FUNC_LOAD : FUNC_SEARCH;
            end else begin
                f = ($urandom_range(0, 99) < 15) ? FUNC_LOAD : FUNC_SEARCH;
            end
            offer_word(f, kh, kl, predicted);
            pending_results.push_back(predicted);
        end
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int  mode;
        int  len;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && words_accepted >= 300) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 200);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2: i_m_axis_tready <= (k % 4) == 0;
                    default: i_m_axis_tready <= (k % 8) < 5;
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser[0] !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_m_axis_tuser[0]);
                    error_count++;
                end
                if (o_m_axis_tdata[5:0] !== want.position) begin
                    $error("position: expected %0d, actual %0d", want.position,
                           o_m_axis_tdata[5:0]);
                    error_count++;
                end
                if (o_m_axis_tuser[1] !== want.table_full) begin
                    $error("table_full: expected %0d, actual %0d", want.table_full,
                           o_m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

endmodule

@@ sim.f @@
hw/rtl/skts_pkg.sv
hw/rtl/sorted_key_table_search_unit.sv
hw/rtl/skts_checker.sv
sim/sorted_key_table_search_unit_tb.sv
